@@ hdl/spim_pkg.sv @@
// spim_pkg: shared codes, widths and payload types of the spi master peripheral
// no dependencies; compile first

package spim_pkg;

  localparam int DATA_W         = 16;
  localparam int MAX_FRAME_BITS = 16;
  localparam int BAUD_W         = 3;
  localparam int DIV_W          = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 3;

  // action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CPOL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPHA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAUD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LSB   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EN    = 3'd5;

  typedef struct packed {
    logic [1:0]        action;
    logic [DATA_W-1:0] write_data;
    logic              miso;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              tx_empty;
    logic              rx_not_empty;
    logic              busy_res;
    logic              overrun;
    logic              sclk;
    logic              mosi;
  } res_t;

endpackage

@@ hdl/spim_chan_if.sv @@
// spim_chan_if: valid/ready channel carrying one payload per transfer
// payload type given by the instantiating module

interface spim_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/spim_core.sv @@
// spim_core: configuration registers, spi state and the per-item next-state logic
// depends on spim_pkg

module spim_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 take,
  input  spim_pkg::req_t                       item,
  input  logic                                 cfg_we,
  input  logic [spim_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spim_pkg::CFG_DATA_W-1:0]      cfg_data,
  output spim_pkg::res_t                       result
);

  localparam int BC_W  = $clog2(2 * spim_pkg::MAX_FRAME_BITS);
  localparam int POS_W = $clog2(spim_pkg::MAX_FRAME_BITS);
  localparam int LEN_W = POS_W + 1;
  localparam int DW    = spim_pkg::DATA_W;

  // configuration
  logic                        cpol;
  logic                        cpha;
  logic [spim_pkg::BAUD_W-1:0] baud;
  logic                        frame_sixteen;
  logic                        lsb_first;
  logic                        enable;

  // state
  logic [DW-1:0]             tx_buffer, tx_buffer_next;
  logic                      tx_full, tx_full_next;
  logic [DW-1:0]             shift_reg, shift_reg_next;
  logic [DW-1:0]             rx_buffer, rx_buffer_next;
  logic                      rx_full, rx_full_next;
  logic [DW-1:0]             rx_shift, rx_shift_next;
  logic                      overrun_flag, overrun_flag_next;
  logic [BC_W-1:0]           bit_count, bit_count_next;
  logic [spim_pkg::DIV_W-1:0] divider_count, divider_count_next;
  logic                      clock_level, clock_level_next;
  logic                      active, active_next;

  logic [spim_pkg::DIV_W-1:0] div_top;
  logic [BC_W-1:0]           edge_m1;
  logic [BC_W:0]             edge_inc;
  logic [BC_W:0]             edge_lim;
  logic                      sample_now;
  logic [POS_W-1:0]          rx_pos;
  logic [BC_W-1:0]           tx_m1;
  logic [POS_W-1:0]          tx_k;
  logic [POS_W-1:0]          tx_pos;
  logic                      mosi_bit;
  logic                      ovr_shown;

  function automatic logic [POS_W-1:0] wire_pos(input logic [POS_W-1:0] k,
                                                input logic fs, input logic lsb);
    logic [LEN_W-1:0] last;
    logic [POS_W-1:0] kc;
    last = fs ? LEN_W'(spim_pkg::MAX_FRAME_BITS - 1) : LEN_W'(7);
    kc   = ({1'b0, k} > last) ? last[POS_W-1:0] : k;
    return lsb ? kc : POS_W'(last - {1'b0, kc});
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cpol          <= 1'b0;
      cpha          <= 1'b0;
      baud          <= '0;
      frame_sixteen <= 1'b0;
      lsb_first     <= 1'b0;
      enable        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        spim_pkg::CFG_CPOL:  cpol          <= cfg_data[0];
        spim_pkg::CFG_CPHA:  cpha          <= cfg_data[0];
        spim_pkg::CFG_BAUD:  baud          <= cfg_data[spim_pkg::BAUD_W-1:0];
        spim_pkg::CFG_FRAME: frame_sixteen <= cfg_data[0];
        spim_pkg::CFG_LSB:   lsb_first     <= cfg_data[0];
        spim_pkg::CFG_EN:    enable        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign div_top  = spim_pkg::DIV_W'((8'd1 << baud) - 8'd1);
  assign edge_m1  = bit_count - 1'b1;
  assign edge_inc = {1'b0, bit_count} + 1'b1;
  assign edge_lim = frame_sixteen ? (BC_W+1)'(2 * spim_pkg::MAX_FRAME_BITS)
                                  : (BC_W+1)'(16);
  assign sample_now = cpha ? bit_count[0] : ~bit_count[0];
  assign rx_pos = wire_pos(cpha ? edge_m1[BC_W-1:1] : bit_count[BC_W-1:1],
                           frame_sixteen, lsb_first);

  always_comb begin
    tx_buffer_next     = tx_buffer;
    tx_full_next       = tx_full;
    shift_reg_next     = shift_reg;
    rx_buffer_next     = rx_buffer;
    rx_full_next       = rx_full;
    rx_shift_next      = rx_shift;
    overrun_flag_next  = overrun_flag;
    bit_count_next     = bit_count;
    divider_count_next = divider_count;
    clock_level_next   = clock_level;
    active_next        = active;
    ovr_shown          = overrun_flag;
    case (item.action)
      spim_pkg::ACT_WRITE: begin
        tx_buffer_next = item.write_data;
        tx_full_next   = 1'b1;
      end
      spim_pkg::ACT_READ: begin
        rx_full_next      = 1'b0;
        overrun_flag_next = 1'b0;
      end
      spim_pkg::ACT_TICK: begin
        if (!active) begin
          if (enable && tx_full) begin
            shift_reg_next     = tx_buffer;
            tx_full_next       = 1'b0;
            rx_shift_next      = '0;
            active_next        = 1'b1;
            bit_count_next     = '0;
            divider_count_next = '0;
            clock_level_next   = cpol;
          end
        end else if (divider_count >= div_top) begin
          divider_count_next = '0;
          clock_level_next   = ~clock_level;
          if (sample_now && item.miso) begin
            for (int i = 0; i < DW; i++) begin
              if (32'(rx_pos) == i) rx_shift_next[i] = 1'b1;
            end
          end
          if (edge_inc >= edge_lim) begin
            active_next      = 1'b0;
            bit_count_next   = '0;
            clock_level_next = cpol;
            if (rx_full) begin
              overrun_flag_next = 1'b1;
            end else begin
              rx_buffer_next = rx_shift_next;
              rx_full_next   = 1'b1;
            end
          end else begin
            bit_count_next = edge_inc[BC_W-1:0];
          end
        end else begin
          divider_count_next = divider_count + 1'b1;
        end
        ovr_shown = overrun_flag_next;
      end
      default: ;
    endcase
  end

  // mosi from the state after this item
  assign tx_m1 = bit_count_next - 1'b1;
  assign tx_k  = cpha ? ((bit_count_next == '0) ? '0 : tx_m1[BC_W-1:1])
                      : bit_count_next[BC_W-1:1];
  assign tx_pos = wire_pos(tx_k, frame_sixteen, lsb_first);

  always_comb begin
    mosi_bit = 1'b0;
    for (int i = 0; i < DW; i++) begin
      if (32'(tx_pos) == i) mosi_bit = shift_reg_next[i];
    end
  end

  always_comb begin
    result.read_data    = (item.action == spim_pkg::ACT_READ) ? rx_buffer : '0;
    result.tx_empty     = ~tx_full_next;
    result.rx_not_empty = rx_full_next;
    result.busy_res     = active_next;
    result.overrun      = ovr_shown;
    result.sclk         = active_next ? clock_level_next : cpol;
    result.mosi         = active_next & mosi_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_full       <= 1'b0;
      rx_buffer     <= '0;
      rx_full       <= 1'b0;
      overrun_flag  <= 1'b0;
      bit_count     <= '0;
      divider_count <= '0;
      clock_level   <= 1'b0;
      active        <= 1'b0;
    end else if (take) begin
      tx_full       <= tx_full_next;
      rx_buffer     <= rx_buffer_next;
      rx_full       <= rx_full_next;
      overrun_flag  <= overrun_flag_next;
      bit_count     <= bit_count_next;
      divider_count <= divider_count_next;
      clock_level   <= clock_level_next;
      active        <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tx_buffer <= tx_buffer_next;
      shift_reg <= shift_reg_next;
      rx_shift  <= rx_shift_next;
    end
  end

  // idle shifter holds no count
  a_idle_counts: assert property (@(posedge clk) disable iff (rst)
    !active |-> (bit_count == '0 && divider_count == '0))
    else $error("counts not cleared while idle");

  // overrun only from a frame end on a tick
  a_overrun_src: assert property (@(posedge clk) disable iff (rst)
    $rose(overrun_flag) |-> $past(take && item.action == spim_pkg::ACT_TICK && active))
    else $error("overrun set without a frame end");

  // a frame starts only by consuming the transmit buffer
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    $rose(active) |-> ($past(tx_full) && !tx_full))
    else $error("frame started without a buffered transfer");

endmodule

@@ hdl/spim_out_reg.sv @@
// spim_out_reg: result register between the core and the result channel
// depends on spim_pkg and spim_chan_if

module spim_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  spim_pkg::res_t     in_data,
  spim_chan_if.source        res
);

  logic           valid;
  spim_pkg::res_t data;

  assign in_ready    = ~valid | res.ready;
  assign res.valid   = valid;
  assign res.payload = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

  // a held result blocks new items
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    (valid && !res.ready) |-> !in_ready)
    else $error("new item taken over a waiting result");

endmodule

@@ hdl/spi_master_peripheral_unit.sv @@
// spi_master_peripheral_unit: spi master peripheral, one result per item
// depends on spim_pkg, spim_chan_if, spim_core, spim_out_reg
//
//   channel  dir  payload                                            transfer when
//   req      in   action, write_data, miso                           valid & ready
//   res      out  read_data, tx_empty, rx_not_empty, busy_res,       valid & ready
//                 overrun, sclk, mosi
//   cfg      in   cfg_index, cfg_data                                cfg_we
//
// one item per cycle while no result is left waiting; its result is in the result register on the next cycle
// the whole item is one pass of next-state logic into the state and result registers
// reset (rst, synchronous) clears all flags, counters and configuration
// a result left waiting holds req.ready low until it is taken

module spi_master_peripheral_unit (
  input  logic                            clk,
  input  logic                            rst,
  spim_chan_if.sink                       req,
  spim_chan_if.source                     res,
  input  logic                            cfg_we,
  input  logic [spim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spim_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic           take;
  logic           ready;
  spim_pkg::res_t result;

  assign req.ready = ready;
  assign take      = req.valid & ready;

  spim_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (req.payload),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  spim_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ready),
    .in_data  (result),
    .res      (res)
  );

endmodule
